>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Antecedent followed by a delayed consequent.
`define ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("%m: delayed check failed");

`endif

>>> src/tlpq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpq_pkg
// Shared types and constants of the three-level priority queue.
// ---------------------------------------------------------------------------
package tlpq_pkg;

	// Parameter defaults
	localparam int MAX_IDS_DEF      = 64;
	localparam int FIFO_DEPTH_DEF   = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Fixed port widths
	localparam int NUM_LEVELS = 3;
	localparam int PORT_ID_W  = 7;
	localparam int PORT_PAY_W = 32;

	// Default width of one stored entry (ID + handle)
	localparam int ENTRY_W_DEF = $clog2(MAX_IDS_DEF + 1) + PAYLOAD_BITS_DEF;

	typedef enum logic [1:0] {
		REQ_ENQUEUE = 2'd0,
		REQ_POP     = 2'd1,
		REQ_RELEASE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NO_ID = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic [1:0] LVL_NORMAL   = 2'd0;
	localparam logic [1:0] LVL_PRIORITY = 2'd1;
	localparam logic [1:0] LVL_MAXIMUM  = 2'd2;

endpackage

>>> src/three_level_priority_queue_with_id_pool.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// three_level_priority_queue_with_id_pool
// Strict-priority request queue (normal, priority, maximum) with an ID pool.
// ---------------------------------------------------------------------------
// One operation (enqueue, pop, release) is taken per clock when start is high;
// busy stays low, so a command can be issued in every cycle. Each command
// gives exactly one result on the status/tag/served ports, marked by done for
// a single cycle, after the command has passed the input register and then
// the result stage, where the per-level FIFO RAM is read. The receiver cannot
// stall; results must be captured when done is high. Enqueue takes the lowest
// free ID; pop serves the oldest entry of the highest non-empty level; release
// frees an ID. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
module three_level_priority_queue_with_id_pool #(
	parameter int MAX_IDS      = tlpq_pkg::MAX_IDS_DEF,
	parameter int FIFO_DEPTH   = tlpq_pkg::FIFO_DEPTH_DEF,
	parameter int PAYLOAD_BITS = tlpq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [1:0]  level,
	input  logic [31:0] payload,
	input  logic [6:0]  release_id,
	output logic        done,
	output logic [1:0]  status,
	output logic [6:0]  tag_id,
	output logic [31:0] served_payload,
	output logic [1:0]  served_level
);

	localparam int NL      = tlpq_pkg::NUM_LEVELS;
	localparam int TAG_W   = tlpq_pkg::PORT_ID_W;
	localparam int OPAY_W  = tlpq_pkg::PORT_PAY_W;
	localparam int ID_W    = $clog2(MAX_IDS + 1);
	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
	localparam int KEEP_W  = (PAYLOAD_BITS < OPAY_W) ? PAYLOAD_BITS : OPAY_W;
	localparam int ENTRY_W = ID_W + KEEP_W;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Input register
	logic              valid_s1;
	logic [1:0]        req_s1;
	logic [1:0]        lvl_s1;
	logic [KEEP_W-1:0] pay_s1;
	logic [TAG_W-1:0]  rid_s1;

	// Queue state
	logic [MAX_IDS-1:0] in_use_q;
	logic [PTR_W-1:0]   head_q [NL];
	logic [PTR_W-1:0]   tail_q [NL];
	logic [CNT_W-1:0]   cnt_q  [NL];

	// Result stage
	logic             valid_s2;
	logic [1:0]       status_s2;
	logic [ID_W-1:0]  tag_s2;
	logic             pop_s2;
	logic [1:0]       slvl_s2;

	// Decode signals
	logic               is_enq, is_pop, is_rel;
	logic [1:0]         lvl_eff;
	logic [MAX_IDS-1:0] free_vec, lowest_oh, clr_mask;
	logic               any_free;
	logic [ID_W-1:0]    free_id;
	logic [NL-1:0]      full, nonempty, enq_here, pop_here;
	logic               enq_ok, pop_ok, rel_ok;
	logic [1:0]         pop_lvl;
	logic [1:0]         status_d;
	logic [ENTRY_W-1:0] rd_data [NL];
	logic [ENTRY_W-1:0] rd_sel;

	assign busy = 1'b0;

	// Capture a command on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req_type;
			lvl_s1 <= level;
			pay_s1 <= payload[KEEP_W-1:0];
			rid_s1 <= release_id;
		end
	end

	// Command decode
	assign is_enq  = valid_s1 && (req_s1 == tlpq_pkg::REQ_ENQUEUE);
	assign is_pop  = valid_s1 && (req_s1 == tlpq_pkg::REQ_POP);
	assign is_rel  = valid_s1 && (req_s1 == tlpq_pkg::REQ_RELEASE);
	assign lvl_eff = (lvl_s1 > tlpq_pkg::LVL_MAXIMUM) ? tlpq_pkg::LVL_MAXIMUM : lvl_s1;

	// Lowest free ID: isolate the lowest set bit of the free vector, then encode
	assign free_vec  = ~in_use_q;
	assign lowest_oh = free_vec & (~free_vec + 1'b1);
	assign any_free  = |free_vec;

	always_comb begin
		free_id = '0;
		for (int k = 0; k < MAX_IDS; k++) begin
			if (lowest_oh[k]) begin
				free_id = free_id | ID_W'(k + 1);
			end
		end
	end

	// Release decode: IDs outside 1..MAX_IDS are ignored
	assign rel_ok   = is_rel && (rid_s1 != '0) && (rid_s1 <= TAG_W'(MAX_IDS));
	assign clr_mask = MAX_IDS'(1) << (rid_s1 - 1'b1);

	// Per-level occupancy flags
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			full[l]     = (cnt_q[l] == CNT_W'(FIFO_DEPTH));
			nonempty[l] = (cnt_q[l] != '0);
		end
	end

	assign enq_ok = is_enq && any_free && !full[lvl_eff];

	// Highest non-empty level wins the pop
	always_comb begin
		priority if (nonempty[tlpq_pkg::LVL_MAXIMUM]) begin
			pop_lvl = tlpq_pkg::LVL_MAXIMUM;
		end else if (nonempty[tlpq_pkg::LVL_PRIORITY]) begin
			pop_lvl = tlpq_pkg::LVL_PRIORITY;
		end else begin
			pop_lvl = tlpq_pkg::LVL_NORMAL;
		end
	end

	assign pop_ok = is_pop && (|nonempty);

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			enq_here[l] = enq_ok && (lvl_eff == 2'(l));
			pop_here[l] = pop_ok && (pop_lvl == 2'(l));
		end
	end

	// Status code; pool exhaustion is checked before level full
	always_comb begin
		unique case (req_s1)
			tlpq_pkg::REQ_ENQUEUE: begin
				if (!any_free) begin
					status_d = tlpq_pkg::ST_NO_ID;
				end else if (full[lvl_eff]) begin
					status_d = tlpq_pkg::ST_FULL;
				end else begin
					status_d = tlpq_pkg::ST_OK;
				end
			end
			tlpq_pkg::REQ_POP: begin
				status_d = (|nonempty) ? tlpq_pkg::ST_OK : tlpq_pkg::ST_EMPTY;
			end
			default: begin
				status_d = tlpq_pkg::ST_OK;
			end
		endcase
	end

	// ID pool and FIFO pointer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int l = 0; l < NL; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			if (enq_ok) begin
				in_use_q <= in_use_q | lowest_oh;
			end else if (rel_ok) begin
				in_use_q <= in_use_q & ~clr_mask;
			end
			for (int l = 0; l < NL; l++) begin
				if (enq_here[l]) begin
					tail_q[l] <= ptr_next(tail_q[l]);
					cnt_q[l]  <= cnt_q[l] + 1'b1;
				end else if (pop_here[l]) begin
					head_q[l] <= ptr_next(head_q[l]);
					cnt_q[l]  <= cnt_q[l] - 1'b1;
				end
			end
		end
	end

	// Entry storage, one RAM per level
	for (genvar g = 0; g < NL; g++) begin : g_lvl
		tlpq_fifo_ram #(
			.DEPTH (FIFO_DEPTH),
			.WIDTH (ENTRY_W)
		) u_ram (
			.clk   (clk),
			.we    (enq_here[g]),
			.waddr (tail_q[g]),
			.wdata ({free_id, pay_s1}),
			.re    (pop_here[g]),
			.raddr (head_q[g]),
			.rdata (rd_data[g])
		);
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_s2 <= status_d;
		tag_s2    <= enq_ok ? free_id : '0;
		pop_s2    <= pop_ok;
		slvl_s2   <= pop_lvl;
	end

	// Popped entries come straight from the RAM read register
	assign rd_sel         = rd_data[slvl_s2];
	assign done           = valid_s2;
	assign status         = status_s2;
	assign tag_id         = pop_s2 ? TAG_W'(rd_sel[ENTRY_W-1:KEEP_W]) : TAG_W'(tag_s2);
	assign served_payload = pop_s2 ? OPAY_W'(rd_sel[KEEP_W-1:0]) : '0;
	assign served_level   = pop_s2 ? slvl_s2 : tlpq_pkg::LVL_NORMAL;

endmodule

>>> src/tlpq_fifo_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpq_fifo_ram
// Storage of one priority level: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tlpq_fifo_ram #(
	parameter int DEPTH = tlpq_pkg::FIFO_DEPTH_DEF,
	parameter int WIDTH = tlpq_pkg::ENTRY_W_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write at the tail, registered read at the head
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/tlpq_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlpq_checker
// Port-level checks of the queue, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tlpq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  req_type,
	input logic        done,
	input logic [1:0]  status,
	input logic [6:0]  tag_id,
	input logic [31:0] served_payload,
	input logic [1:0]  served_level
);

	logic cmd_xfer;
	assign cmd_xfer = start && !busy;

	// Every transfer yields one result
	`ASSERT_DLY(a_result_follows, clk, arst_n, cmd_xfer, 2, done)

	// No result without an earlier transfer
	`ASSERT_IMP(a_no_spurious_result, clk, arst_n, done, $past(cmd_xfer && arst_n, 2))

	// An empty pop carries no entry
	`ASSERT_IMP(a_empty_pop_clean, clk, arst_n, done && (status == tlpq_pkg::ST_EMPTY), (tag_id == '0) && (served_payload == '0) && (served_level == tlpq_pkg::LVL_NORMAL))

	// A successful enqueue hands out a real ID
	`ASSERT_IMP(a_enq_gets_id, clk, arst_n, done && (status == tlpq_pkg::ST_OK) && $past(req_type == tlpq_pkg::REQ_ENQUEUE, 2), tag_id != '0)

endmodule

bind three_level_priority_queue_with_id_pool tlpq_checker u_tlpq_checker (.*);
